// File: src/tccw_pkg.sv
// ============================================================================
// tccw_pkg - shared types and constants for the text console char writer
// Grid defaults, field widths, control codes, action codes and FSM states.
// ============================================================================
package tccw_pkg;

  // Default grid geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Beat field widths
  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_IDX_W = 11;
  localparam int POS_W      = 11;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam int                TAB_STOP   = 8;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

endpackage

// File: src/tccw_cmd_if.sv
// ============================================================================
// tccw_cmd_if - command channel
// Valid/ready channel carrying one console action per beat.
// ============================================================================
interface tccw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [tccw_pkg::ACTION_W-1:0]     action;
  logic [tccw_pkg::CHAR_W-1:0]       char_code;
  logic [tccw_pkg::CELL_IDX_W-1:0]   cell_index;

  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

// File: src/tccw_res_if.sv
// ============================================================================
// tccw_res_if - result channel
// Valid/ready channel carrying one step result per beat.
// ============================================================================
interface tccw_res_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::POS_W-1:0]    cursor_position;
  logic [tccw_pkg::CHAR_W-1:0]   cell_char;
  logic [tccw_pkg::ATTR_W-1:0]   cell_attr;
  logic                          scrolled;

  modport source (output valid, cursor_position, cell_char, cell_attr, scrolled,
                  input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, scrolled,
                  output ready);
endinterface

// File: src/text_console_char_writer_unit.sv
// ============================================================================
// text_console_char_writer_unit - text console character writer
// Cell grid in one synchronous RAM plus a cursor; put, read and clear actions.
// ============================================================================
// Sequence: put, read and unused actions go from ST_IDLE to ST_EMIT, where
//   the result beat is registered once the output is free; a put that scrolls
//   first passes through ST_SCROLL (one cell copied per cycle through the
//   single RAM write port) and ST_BLANK, clear through ST_CLEAR (one cell
//   blanked per cycle). Commands are taken one at a time, in ST_IDLE only.
// Reset: a clearing pass zeroes all ROWS*COLUMNS cells with cmd.ready low;
//   the attribute register resets to 7.
// ============================================================================
module text_console_char_writer_unit #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tccw_cmd_if.sink                      cmd,
  tccw_res_if.source                    res,
  input  logic                          cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_wr_data
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int CLW        = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  // First cell of the bottom row: the scroll copy stops here
  localparam int SCROLL_END = CELLS - COLUMNS;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  tccw_pkg::state_t            state, state_next;
  logic [CLW-1:0]              col, col_next;
  logic [RW-1:0]               row, row_next;
  logic [AW-1:0]               cnt, cnt_next;
  logic [tccw_pkg::ATTR_W-1:0] attr;

  // Scroll copy pipeline: the read issued last cycle lands at cp_dst
  logic                        cp_valid, cp_valid_next;
  logic [AW-1:0]               cp_dst, cp_dst_next;

  // Result bookkeeping for the pending beat
  logic                        pend_scroll, pend_scroll_next;
  logic                        pend_rd, pend_rd_next;

  // --------------------------------------------------------------------------
  // Cell RAM: one write port, one registered read port
  // --------------------------------------------------------------------------
  tccw_pkg::cell_t             mem [CELLS];
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  tccw_pkg::cell_t             wr_data, rd_data;
  tccw_pkg::cell_t             blank_cell;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign blank_cell = '{attr: attr, ch: tccw_pkg::CH_BLANK};

  // --------------------------------------------------------------------------
  // Put decode: where the cursor goes and which cell gets written
  // --------------------------------------------------------------------------
  logic [31:0] col32, row32, tab_col, put_col, put_row, wcol;
  logic        put_wr, put_scroll, cmd_go, rd_in_range;
  logic [tccw_pkg::CHAR_W-1:0] put_ch;
  logic [RW-1:0]               put_row_fin;
  logic [CLW-1:0]              put_col_fin;

  always_comb begin
    col32   = 32'(col);
    row32   = 32'(row);
    // Round up to the next tab stop, then step one past it
    tab_col = ((col32 + 32'(tccw_pkg::TAB_STOP - 1)) & ~32'(tccw_pkg::TAB_STOP - 1)) + 32'd1;
    put_col = col32;
    put_row = row32;
    wcol    = col32;
    put_wr  = 1'b0;
    put_ch  = cmd.char_code;
    priority if (cmd.char_code == tccw_pkg::CH_NEWLINE) begin
      put_col = 32'd0;
      put_row = row32 + 32'd1;
    end else if (cmd.char_code == tccw_pkg::CH_BACKSPACE) begin
      // Hold column zero; the space still lands there
      put_col = (col32 == 32'd0) ? 32'd0 : col32 - 32'd1;
      wcol    = put_col;
      put_wr  = 1'b1;
      put_ch  = tccw_pkg::CH_SPACE;
    end else if (cmd.char_code == tccw_pkg::CH_TAB) begin
      if (tab_col >= 32'(COLUMNS)) begin
        put_col = 32'd0;
        put_row = row32 + 32'd1;
      end else begin
        put_col = tab_col;
      end
    end else begin
      put_wr = 1'b1;
      if (col32 + 32'd1 >= 32'(COLUMNS)) begin
        put_col = 32'd0;
        put_row = row32 + 32'd1;
      end else begin
        put_col = col32 + 32'd1;
      end
    end
    put_scroll  = (put_row >= 32'(ROWS));
    put_row_fin = put_scroll ? RW'(ROWS - 1) : RW'(put_row);
    put_col_fin = CLW'(put_col);
  end

  assign cmd_go      = (state == tccw_pkg::ST_IDLE) && cmd.valid;
  assign rd_in_range = (32'(cmd.cell_index) < 32'(CELLS));

  logic out_free;
  assign out_free = !res.valid || res.ready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      tccw_pkg::ST_INIT: begin
        if (cnt == AW'(CELLS - 1)) begin
          state_next = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.action)
            tccw_pkg::ACT_PUT:   state_next = put_scroll ? tccw_pkg::ST_SCROLL
                                                         : tccw_pkg::ST_EMIT;
            tccw_pkg::ACT_CLEAR: state_next = tccw_pkg::ST_CLEAR;
            default:             state_next = tccw_pkg::ST_EMIT;
          endcase
        end
      end
      tccw_pkg::ST_SCROLL: begin
        if (cnt == AW'(SCROLL_END)) begin
          state_next = tccw_pkg::ST_BLANK;
        end
      end
      tccw_pkg::ST_BLANK,
      tccw_pkg::ST_CLEAR: begin
        if (cnt == AW'(CELLS - 1)) begin
          state_next = tccw_pkg::ST_EMIT;
        end
      end
      tccw_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = tccw_pkg::ST_IDLE;
        end
      end
      default: state_next = tccw_pkg::ST_INIT;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: RAM controls, cursor, sweep counter, copy pipeline
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = cnt;
    wr_data          = blank_cell;
    rd_en            = 1'b0;
    rd_addr          = AW'(cmd.cell_index);
    cmd.ready        = 1'b0;
    col_next         = col;
    row_next         = row;
    cnt_next         = cnt;
    cp_valid_next    = 1'b0;
    cp_dst_next      = cp_dst;
    pend_scroll_next = pend_scroll;
    pend_rd_next     = pend_rd;
    unique case (state)
      tccw_pkg::ST_INIT: begin
        // Zero the grid after reset
        wr_en    = 1'b1;
        wr_data  = '0;
        cnt_next = (cnt == AW'(CELLS - 1)) ? '0 : cnt + AW'(1);
      end
      tccw_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd_go) begin
          pend_scroll_next = 1'b0;
          pend_rd_next     = 1'b0;
          cnt_next         = '0;
          unique case (cmd.action)
            tccw_pkg::ACT_PUT: begin
              wr_en            = put_wr;
              wr_addr          = AW'(row32 * 32'(COLUMNS) + wcol);
              wr_data          = '{attr: attr, ch: put_ch};
              col_next         = put_col_fin;
              row_next         = put_row_fin;
              pend_scroll_next = put_scroll;
            end
            tccw_pkg::ACT_READ: begin
              rd_en        = rd_in_range;
              pend_rd_next = rd_in_range;
            end
            tccw_pkg::ACT_CLEAR: begin
              col_next = '0;
              row_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      tccw_pkg::ST_SCROLL: begin
        // Land the previous read one row up, fetch the next source cell
        wr_en   = cp_valid;
        wr_addr = cp_dst;
        wr_data = rd_data;
        if (cnt != AW'(SCROLL_END)) begin
          rd_en         = 1'b1;
          rd_addr       = AW'(32'(cnt) + 32'(COLUMNS));
          cp_valid_next = 1'b1;
          cp_dst_next   = cnt;
          cnt_next      = cnt + AW'(1);
        end
      end
      tccw_pkg::ST_BLANK,
      tccw_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        cnt_next = (cnt == AW'(CELLS - 1)) ? '0 : cnt + AW'(1);
      end
      tccw_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tccw_pkg::ST_INIT;
      col         <= '0;
      row         <= '0;
      cnt         <= '0;
      cp_valid    <= 1'b0;
      pend_scroll <= 1'b0;
      pend_rd     <= 1'b0;
      attr        <= tccw_pkg::ATTR_RESET;
    end else begin
      state       <= state_next;
      col         <= col_next;
      row         <= row_next;
      cnt         <= cnt_next;
      cp_valid    <= cp_valid_next;
      pend_scroll <= pend_scroll_next;
      pend_rd     <= pend_rd_next;
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_dst <= cp_dst_next;
  end

  // --------------------------------------------------------------------------
  // Result register: holds a finished beat while the next command comes in
  // --------------------------------------------------------------------------
  logic load_res;
  assign load_res = (state == tccw_pkg::ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_res) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.cursor_position <= tccw_pkg::POS_W'(row32 * 32'(COLUMNS) + col32);
      res.cell_char       <= pend_rd ? rd_data.ch   : '0;
      res.cell_attr       <= pend_rd ? rd_data.attr : '0;
      res.scrolled        <= pend_scroll;
    end
  end

endmodule

// File: src/tccw_checker.sv
// ============================================================================
// tccw_checker - port-level checks for the text console char writer
// Watches the command and result channels of the top level.
// ============================================================================
module tccw_checker #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [tccw_pkg::POS_W-1:0]      res_cursor_position,
  input logic [tccw_pkg::CHAR_W-1:0]     res_cell_char,
  input logic [tccw_pkg::ATTR_W-1:0]     res_cell_attr,
  input logic                            res_scrolled
);

  localparam int CELLS = COLUMNS * ROWS;

  // Stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_cursor_position)
      && $stable(res_cell_char) && $stable(res_cell_attr) && $stable(res_scrolled))
    else $error("result beat changed while stalled");

  // One command in flight: ready drops after every command beat
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in flight");

  // Only a put scrolls, and a put returns no cell
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_scrolled |-> res_cell_char == '0 && res_cell_attr == '0)
    else $error("scrolled beat carries cell data");

  // Cursor stays inside the grid
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (CELLS > 2047) || (32'(res_cursor_position) < 32'(CELLS)))
    else $error("cursor outside the grid");

endmodule

bind text_console_char_writer_unit tccw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccw_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_cursor_position(res.cursor_position),
  .res_cell_char      (res.cell_char),
  .res_cell_attr      (res.cell_attr),
  .res_scrolled       (res.scrolled)
);
